### hw/rtl/isa_pkg.sv
`timescale 1ns / 1ps

package isa_pkg;

    localparam int DEPTH_DEF = 256;

    localparam int FUNC_W   = 4;
    localparam int INDEX_W  = 8;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int REMCNT_W = 9;
    localparam int USED_W   = 9;

    localparam logic [FUNC_W-1:0] FN_PUSH   = 4'd0;
    localparam logic [FUNC_W-1:0] FN_POP    = 4'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT = 4'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 4'd3;
    localparam logic [FUNC_W-1:0] FN_GET    = 4'd4;
    localparam logic [FUNC_W-1:0] FN_SET    = 4'd5;
    localparam logic [FUNC_W-1:0] FN_FIND   = 4'd6;
    localparam logic [FUNC_W-1:0] FN_PURGE  = 4'd7;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 4'd8;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_FULL   = 2'd2,
        ST_SETIGN = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_LAST,
        S_REM,
        S_READ,
        S_FIND,
        S_PURGE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [INDEX_W-1:0]        index;
        logic signed [DATA_W-1:0]  value;
    } t_in;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  read_value;
        logic                      found;
        logic [POS_W-1:0]          position;
        logic [REMCNT_W-1:0]       removed_count;
        logic [USED_W-1:0]         used_count;
    } t_out;

endpackage

### hw/rtl/isa_ram.sv
`timescale 1ns / 1ps

module isa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/indexed_shift_array_core.sv
`timescale 1ns / 1ps

// Ordered array of signed 32-bit entries with a fill count, held in one RAM.
// Input channel i_valid/o_stall carries one operation (push, pop, insert,
// remove, get, set, find, purge, clear); output channel o_valid/i_stall
// returns exactly one result per operation, held in an output register.
// A transaction is accepted only while the sequencer is idle; a new one may
// be taken while the previous result still waits in the output register.
// Push, set, clear and range or full errors go straight to the finishing
// step; pop and get read one entry; insert moves the entries above the index
// up and remove moves them down; find scans until a match and purge scans
// every entry below the fill count. Every shift, search and compaction step
// goes through the single RAM read and write port, one entry a cycle.
// Reset clears the fill count and the sequencer at once; the RAM needs no
// clearing pass, as only entries below the fill count are ever read.
// While the receiver stalls, the result holds; a finished operation then
// waits before the output register until it frees, and input stays stalled.
module indexed_shift_array_core #(
    parameter int DEPTH = isa_pkg::DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  isa_pkg::t_in i_item,
    output logic         o_valid,
    input  logic         i_stall,
    output isa_pkg::t_out o_result
);

    import isa_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_idx, n_idx;
    logic [DATA_W-1:0]        r_val, n_val;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [CW-1:0]            r_rptr, n_rptr;
    logic [CW-1:0]            r_wptr, n_wptr;
    logic [CW-1:0]            r_removed, n_removed;
    t_status                  r_status, n_status;
    logic [DATA_W-1:0]        r_rd, n_rd;
    logic                     r_found, n_found;
    logic                     r_out_valid, n_out_valid;
    t_out                     r_out, n_out;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    logic [XW-1:0]            x_idx, x_cnt;
    logic                     full, empty, more;

    isa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign x_idx = XW'(i_item.index);
    assign x_cnt = XW'(r_cnt);
    assign full  = (r_cnt == CW'(DEPTH));
    assign empty = (r_cnt == '0);
    assign more  = ((r_rptr + CW'(1)) < r_cnt);

    // Read data always belongs to r_rptr: issue the read of the next pointer.
    assign ram_raddr = n_rptr[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_val       = r_val;
        n_cnt       = r_cnt;
        n_rptr      = r_rptr;
        n_wptr      = r_wptr;
        n_removed   = r_removed;
        n_status    = r_status;
        n_rd        = r_rd;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_wptr[AW-1:0];
        ram_wdata   = ram_rdata;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_idx     = CW'(i_item.index);
                    n_val     = i_item.value;
                    n_removed = '0;
                    n_status  = ST_OK;
                    n_rd      = '0;
                    n_found   = 1'b0;
                    n_state   = S_FINISH;
                    unique case (i_item.func)
                        FN_PUSH: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_cnt[AW-1:0];
                                ram_wdata = i_item.value;
                                n_cnt     = r_cnt + CW'(1);
                            end
                        end
                        FN_POP: begin
                            if (empty) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_cnt   = r_cnt - CW'(1);
                                n_rptr  = r_cnt - CW'(1);
                                n_state = S_READ;
                            end
                        end
                        FN_INSERT: begin
                            if (x_idx > x_cnt) begin
                                n_status = ST_RANGE;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else if (x_idx == x_cnt) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_cnt[AW-1:0];
                                ram_wdata = i_item.value;
                                n_cnt     = r_cnt + CW'(1);
                            end else begin
                                n_rptr  = r_cnt - CW'(1);
                                n_state = S_INS;
                            end
                        end
                        FN_REMOVE: begin
                            if (x_idx >= x_cnt) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_rptr  = CW'(i_item.index);
                                n_state = S_REM;
                            end
                        end
                        FN_GET: begin
                            if (x_idx >= x_cnt) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_rptr  = CW'(i_item.index);
                                n_state = S_READ;
                            end
                        end
                        FN_SET: begin
                            if (x_idx >= x_cnt) begin
                                n_status = ST_SETIGN;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(i_item.index);
                                ram_wdata = i_item.value;
                            end
                        end
                        FN_FIND: begin
                            if (!empty) begin
                                n_rptr  = '0;
                                n_state = S_FIND;
                            end
                        end
                        FN_PURGE: begin
                            if (!empty) begin
                                n_rptr  = '0;
                                n_wptr  = '0;
                                n_state = S_PURGE;
                            end
                        end
                        FN_CLEAR: begin
                            n_cnt = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Walk down from the top: entry r_rptr moves up by one.
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_rptr + CW'(1));
                if (r_rptr == r_idx) begin
                    n_state = S_INS_LAST;
                end else begin
                    n_rptr = r_rptr - CW'(1);
                end
            end

            S_INS_LAST: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                ram_wdata = r_val;
                n_cnt     = r_cnt + CW'(1);
                n_state   = S_FINISH;
            end

            // First read returns the removed entry; later ones move down by one.
            S_REM: begin
                if (r_rptr == r_idx) begin
                    n_rd = ram_rdata;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_rptr - CW'(1));
                end
                if (more) begin
                    n_rptr = r_rptr + CW'(1);
                end else begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = S_FINISH;
                end
            end

            S_READ: begin
                n_rd    = ram_rdata;
                n_state = S_FINISH;
            end

            S_FIND: begin
                if (ram_rdata == r_val) begin
                    n_found = 1'b1;
                    n_state = S_FINISH;
                end else if (more) begin
                    n_rptr = r_rptr + CW'(1);
                end else begin
                    n_state = S_FINISH;
                end
            end

            // Compact survivors towards the bottom; the write never passes the read.
            S_PURGE: begin
                if (ram_rdata == r_val) begin
                    n_removed = r_removed + CW'(1);
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wptr[AW-1:0];
                    n_wptr    = r_wptr + CW'(1);
                end
                if (more) begin
                    n_rptr = r_rptr + CW'(1);
                end else begin
                    n_cnt   = n_wptr;
                    n_state = S_FINISH;
                end
            end

            // Hold until the output register is free.
            S_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid          = 1'b1;
                    n_out.status         = r_status;
                    n_out.read_value     = r_rd;
                    n_out.found          = r_found;
                    n_out.position       = r_found ? POS_W'(r_rptr) : '0;
                    n_out.removed_count  = REMCNT_W'(r_removed);
                    n_out.used_count     = USED_W'(r_cnt);
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_val     <= n_val;
        r_rptr    <= n_rptr;
        r_wptr    <= n_wptr;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_rd      <= n_rd;
        r_found   <= n_found;
        r_out     <= n_out;
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
